[hw/rtl/rud_pkg.sv]
// Shared constants for the restoring unsigned divider.
`timescale 1ns / 1ps

package rud_pkg;

    localparam int DEF_WIDTH = 32;
    localparam int MIN_WIDTH = 8;
    localparam int MAX_WIDTH = 64;

endpackage

[hw/rtl/rud_cell.sv]
// One restoring division step: shift in a dividend bit, trial subtract, register.
`timescale 1ns / 1ps

module rud_cell #(
    parameter int WIDTH = rud_pkg::DEF_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             valid_in,
    input  logic [WIDTH-1:0] rem_in,
    input  logic [WIDTH-1:0] quo_in,
    input  logic [WIDTH-1:0] den_in,
    output logic             valid_out,
    output logic [WIDTH-1:0] rem_out,
    output logic [WIDTH-1:0] quo_out,
    output logic [WIDTH-1:0] den_out
);

    logic             valid_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] den_reg;

    logic             guard;
    logic [WIDTH-1:0] shifted;
    logic             take;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    always_comb
    begin
        guard    = rem_in[WIDTH-1];
        shifted  = {rem_in[WIDTH-2:0], quo_in[WIDTH-1]};
        take     = guard || (shifted >= den_in);
        rem_next = take ? (shifted - den_in) : shifted;
        quo_next = {quo_in[WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign den_out   = den_reg;

endmodule

[hw/rtl/rud_skid.sv]
// Output register with a skid slot that lets the cell chain run while a result waits.
`timescale 1ns / 1ps

module rud_skid #(
    parameter int WIDTH = rud_pkg::DEF_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             in_ready,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data,
    input  logic             out_ready
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic             load_out;
    logic             load_skid;

    always_comb
    begin
        load_out        = out_ready || !out_valid_reg;
        load_skid       = !load_out && in_valid;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_out)
        begin
            out_valid_next  = skid_valid_reg || in_valid;
            skid_valid_next = 1'b0;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds data while output is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && in_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("stalled result did not move into skid slot");

    a_drain_empties_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid slot did not drain to output");

    a_no_input_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !in_ready)
        else $error("input offered while skid slot is full");

endmodule

[hw/rtl/restoring_unsigned_divider.sv]
// Top level: pipelined restoring unsigned divider, one cell per quotient bit.
//
// channel  role    fields (tdata, lowest bit up)
// s_axis   input   dividend[WIDTH], divisor[WIDTH], zero fill to bytes
// m_axis   output  quotient[WIDTH], zero fill to bytes
//
// A result passes through one cell per quotient bit, then the output register.
// One transaction enters per cycle while the skid slot behind the chain is empty.
// A stalled output fills the skid slot; s_tready then drops until it drains.
// Reset clears only the valid bits; a zero divisor gives an all-ones quotient.
`timescale 1ns / 1ps

module restoring_unsigned_divider #(
    parameter int WIDTH = rud_pkg::DEF_WIDTH,
    localparam int IN_BITS  = ((2 * WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS = ((WIDTH + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,   // dividend, divisor
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata    // quotient
);

    logic             valid_w [0:WIDTH];
    logic [WIDTH-1:0] rem_w   [0:WIDTH];
    logic [WIDTH-1:0] quo_w   [0:WIDTH];
    logic [WIDTH-1:0] den_w   [0:WIDTH];
    logic             advance;
    logic [WIDTH-1:0] quotient;

    assign advance  = s_tready;
    assign valid_w[0] = s_tvalid;
    assign rem_w[0]   = '0;
    assign quo_w[0]   = s_tdata[WIDTH-1:0];
    assign den_w[0]   = s_tdata[2*WIDTH-1:WIDTH];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        rud_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .valid_in (valid_w[i]),
            .rem_in   (rem_w[i]),
            .quo_in   (quo_w[i]),
            .den_in   (den_w[i]),
            .valid_out(valid_w[i+1]),
            .rem_out  (rem_w[i+1]),
            .quo_out  (quo_w[i+1]),
            .den_out  (den_w[i+1])
        );
    end

    rud_skid #(
        .WIDTH(WIDTH)
    ) u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_w[WIDTH] && advance),
        .in_data  (quo_w[WIDTH]),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_data (quotient),
        .out_ready(m_tready)
    );

    assign m_tdata = OUT_BITS'(quotient);

endmodule
